[design/limit_order_matcher_core_assert.svh]
// assertion macros shared by the matcher
`ifndef LIMIT_ORDER_MATCHER_CORE_ASSERT_SVH
`define LIMIT_ORDER_MATCHER_CORE_ASSERT_SVH

// same-cycle implication
`define LOM_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("matcher check failed");

// next-cycle implication
`define LOM_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("matcher check failed");

`endif

[design/lom_pkg.sv]
package lom_pkg;

	// report status codes
	localparam logic [1:0] ST_NEW     = 2'd0;
	localparam logic [1:0] ST_PARTIAL = 2'd1;
	localparam logic [1:0] ST_FILL    = 2'd2;
	localparam logic [1:0] ST_REJECT  = 2'd3;

	localparam logic SIDE_BUY  = 1'b0;
	localparam logic SIDE_SELL = 1'b1;

	typedef struct packed {
		logic [31:0] order_tag;
		logic [15:0] client_tag;
		logic        side;
		logic [31:0] limit_price;
		logic [15:0] order_quantity;
	} order_word_t;

	typedef struct packed {
		logic [31:0] report_tag;
		logic [15:0] report_client;
		logic        report_side;
		logic [31:0] report_price;
		logic [15:0] report_quantity;
		logic [1:0]  report_status;
		logic        report_last;
	} report_word_t;

	// one resting book entry
	typedef struct packed {
		logic        valid;
		logic [31:0] price;
		logic [15:0] qty;
		logic [31:0] tag;
		logic [15:0] client;
	} entry_t;

	typedef enum logic [1:0] {
		CMD_NONE,
		CMD_DEC,
		CMD_REMOVE,
		CMD_INSERT
	} cmd_op_t;

	// update broadcast to every cell of a book
	typedef struct packed {
		cmd_op_t op;
		entry_t  entry;
	} cmd_t;

endpackage

[design/limit_order_matcher_core.sv]
// channel | direction | payload        | handshake
// order   | in        | order_word_t   | order_valid / order_stall
// report  | out       | report_word_t  | report_valid / report_stall
//
// each order waits for the best-price search to ripple through the cell row,
// then each match sends an incoming-side and a resting-side report word, and an
// order with quantity left ends with a final new or reject word; report stalls hold it
// arst_n clears both books and the controller; one report word is held in an
// output register, so the next order is taken while the last word still waits
module limit_order_matcher_core import lom_pkg::*; #(
	parameter int BOOK_DEPTH = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         order_valid,
	output logic         order_stall,
	input  order_word_t  order,
	output logic         report_valid,
	input  logic         report_stall,
	output report_word_t report
);

	localparam int IDX_W = (BOOK_DEPTH > 1) ? $clog2(BOOK_DEPTH) : 1;
	localparam int CNT_W = $clog2(BOOK_DEPTH + 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SEARCH,
		S_REP_IN,
		S_REP_REST,
		S_FINAL
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;
	order_word_t      ord_q;
	logic [15:0]      rem_q;
	entry_t           m_q;
	logic [15:0]      m_t_q;
	logic [IDX_W-1:0] m_idx_q;
	report_word_t     rep_q;
	logic             rep_valid_q;

	cmd_t             bid_cmd, ask_cmd;
	entry_t           bid_best, ask_best, opp_best;
	logic [IDX_W-1:0] bid_idx, ask_idx, opp_idx;
	logic             bid_full, ask_full, own_full;
	logic             crosses, out_free, fin_new, rep_load;
	cmd_t             match_cmd, ins_cmd;
	logic [15:0]      t_now;

	lom_book #(.DEPTH(BOOK_DEPTH), .IDX_W(IDX_W), .IS_ASK(1'b0)) u_bid (
		.clk (clk), .arst_n (arst_n), .cmd (bid_cmd), .cmd_idx (m_idx_q),
		.best (bid_best), .best_idx (bid_idx), .full (bid_full)
	);

	lom_book #(.DEPTH(BOOK_DEPTH), .IDX_W(IDX_W), .IS_ASK(1'b1)) u_ask (
		.clk (clk), .arst_n (arst_n), .cmd (ask_cmd), .cmd_idx (m_idx_q),
		.best (ask_best), .best_idx (ask_idx), .full (ask_full)
	);

	// opposite book view and crossing test
	assign opp_best = (ord_q.side == SIDE_SELL) ? bid_best : ask_best;
	assign opp_idx  = (ord_q.side == SIDE_SELL) ? bid_idx : ask_idx;
	assign own_full = (ord_q.side == SIDE_SELL) ? ask_full : bid_full;
	assign crosses  = (ord_q.side == SIDE_SELL) ? (opp_best.price >= ord_q.limit_price)
	                                            : (opp_best.price <= ord_q.limit_price);
	assign t_now    = (rem_q < opp_best.qty) ? rem_q : opp_best.qty;
	assign out_free = !rep_valid_q || !report_stall;
	assign fin_new  = (rem_q != 16'd0) && !own_full;
	assign rep_load = out_free && (state_q == S_REP_IN || state_q == S_REP_REST ||
		state_q == S_FINAL);

	// book commands
	always_comb begin
		match_cmd.op           = (m_q.qty == m_t_q) ? CMD_REMOVE : CMD_DEC;
		match_cmd.entry        = m_q;
		match_cmd.entry.qty    = m_q.qty - m_t_q;
		ins_cmd.op             = CMD_INSERT;
		ins_cmd.entry.valid    = 1'b1;
		ins_cmd.entry.price    = ord_q.limit_price;
		ins_cmd.entry.qty      = rem_q;
		ins_cmd.entry.tag      = ord_q.order_tag;
		ins_cmd.entry.client   = ord_q.client_tag;
		bid_cmd                = '0;
		ask_cmd                = '0;
		bid_cmd.op             = CMD_NONE;
		ask_cmd.op             = CMD_NONE;
		if (state_q == S_REP_REST && out_free) begin
			if (ord_q.side == SIDE_SELL) bid_cmd = match_cmd;
			else ask_cmd = match_cmd;
		end else if (state_q == S_FINAL && out_free && fin_new) begin
			if (ord_q.side == SIDE_SELL) ask_cmd = ins_cmd;
			else bid_cmd = ins_cmd;
		end
	end

	assign order_stall = (state_q != S_IDLE);

	// controller and report register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			rep_valid_q <= 1'b0;
			ord_q       <= '0;
			rem_q       <= '0;
			m_q         <= '0;
			m_t_q       <= '0;
			m_idx_q     <= '0;
			rep_q       <= '0;
		end else begin
			if (rep_load) rep_valid_q <= 1'b1;
			else if (!report_stall) rep_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (order_valid) begin
						ord_q <= order;
						rem_q <= order.order_quantity;
						cnt_q <= '0;
						state_q <= (order.order_quantity == 16'd0) ? S_FINAL : S_SEARCH;
					end
				end
				S_SEARCH: begin
					if (cnt_q == CNT_W'(BOOK_DEPTH)) begin
						m_q     <= opp_best;
						m_t_q   <= t_now;
						m_idx_q <= opp_idx;
						state_q <= (opp_best.valid && crosses) ? S_REP_IN : S_FINAL;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_REP_IN: begin
					if (out_free) begin
						rep_q.report_tag      <= ord_q.order_tag;
						rep_q.report_client   <= ord_q.client_tag;
						rep_q.report_side     <= ord_q.side;
						rep_q.report_price    <= m_q.price;
						rep_q.report_quantity <= m_t_q;
						rep_q.report_status   <= (rem_q <= m_q.qty) ? ST_FILL : ST_PARTIAL;
						rep_q.report_last     <= 1'b0;
						state_q               <= S_REP_REST;
					end
				end
				S_REP_REST: begin
					if (out_free) begin
						rep_q.report_tag      <= m_q.tag;
						rep_q.report_client   <= m_q.client;
						rep_q.report_side     <= ~ord_q.side;
						rep_q.report_price    <= m_q.price;
						rep_q.report_quantity <= m_t_q;
						rep_q.report_status   <= (m_q.qty <= rem_q) ? ST_FILL : ST_PARTIAL;
						rep_q.report_last     <= (rem_q == m_t_q);
						rem_q                 <= rem_q - m_t_q;
						cnt_q                 <= '0;
						state_q               <= (rem_q == m_t_q) ? S_IDLE : S_SEARCH;
					end
				end
				S_FINAL: begin
					if (out_free) begin
						rep_q.report_tag      <= ord_q.order_tag;
						rep_q.report_client   <= ord_q.client_tag;
						rep_q.report_side     <= ord_q.side;
						rep_q.report_price    <= ord_q.limit_price;
						rep_q.report_quantity <= rem_q;
						rep_q.report_status   <= fin_new ? ST_NEW : ST_REJECT;
						rep_q.report_last     <= 1'b1;
						state_q               <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign report_valid = rep_valid_q;
	assign report       = rep_q;

	`include "limit_order_matcher_core_assert.svh"

	// a resting-new word always closes its order
	`LOM_ASSERT_NOW(a_new_is_last, rep_valid_q && rep_q.report_status == ST_NEW, rep_q.report_last)
	// a search only runs with quantity left
	`LOM_ASSERT_NOW(a_search_has_rem, state_q == S_SEARCH, rem_q != 16'd0)
	// a matched quantity never exceeds what remains
	`LOM_ASSERT_NOW(a_trade_bounded, state_q == S_REP_IN, m_t_q <= rem_q && m_t_q != 16'd0)
	// the incoming side report is always followed by the resting side report
	`LOM_ASSERT_NEXT(a_pair, state_q == S_REP_IN && out_free, state_q == S_REP_REST)

endmodule

[design/lom_cell.sv]
module lom_cell import lom_pkg::*; #(
	parameter int IDX_W  = 4,
	parameter int IDX    = 0,
	parameter bit IS_ASK = 1'b0
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cmd_t             cmd,
	input  logic [IDX_W-1:0] cmd_idx,
	input  logic             left_valid,
	input  entry_t           right_entry,
	input  entry_t           best_in,
	input  logic [IDX_W-1:0] best_idx_in,
	output entry_t           entry,
	output entry_t           best_out,
	output logic [IDX_W-1:0] best_idx_out
);

	entry_t           ent_q;
	entry_t           ent_d;
	entry_t           best_q;
	logic [IDX_W-1:0] best_idx_q;
	logic             take;

	// entry update from the broadcast command
	always_comb begin
		ent_d = ent_q;
		case (cmd.op)
			CMD_REMOVE: begin
				if (IDX_W'(IDX) >= cmd_idx) ent_d = right_entry;
			end
			CMD_DEC: begin
				if (IDX_W'(IDX) == cmd_idx) ent_d.qty = cmd.entry.qty;
			end
			CMD_INSERT: begin
				if (!ent_q.valid && left_valid) ent_d = cmd.entry;
			end
			default: ent_d = ent_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_q <= '0;
		end else begin
			ent_q <= ent_d;
		end
	end

	// best-so-far handed to the next cell, earliest wins ties
	assign take = ent_q.valid && (!best_in.valid ||
		(IS_ASK ? (ent_q.price < best_in.price) : (ent_q.price > best_in.price)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q     <= '0;
			best_idx_q <= '0;
		end else begin
			best_q     <= take ? ent_q : best_in;
			best_idx_q <= take ? IDX_W'(IDX) : best_idx_in;
		end
	end

	assign entry        = ent_q;
	assign best_out     = best_q;
	assign best_idx_out = best_idx_q;

endmodule

[design/lom_book.sv]
module lom_book import lom_pkg::*; #(
	parameter int DEPTH  = 16,
	parameter int IDX_W  = 4,
	parameter bit IS_ASK = 1'b0
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cmd_t             cmd,
	input  logic [IDX_W-1:0] cmd_idx,
	output entry_t           best,
	output logic [IDX_W-1:0] best_idx,
	output logic             full
);

	entry_t           ent   [DEPTH];
	entry_t           bchain[DEPTH+1];
	logic [IDX_W-1:0] ichain[DEPTH+1];

	assign bchain[0] = '0;
	assign ichain[0] = '0;

	// row of cells, best search ripples one cell per cycle
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic   lv;
		entry_t re;
		if (i == 0) begin : g_first
			assign lv = 1'b1;
		end else begin : g_mid
			assign lv = ent[i-1].valid;
		end
		if (i == DEPTH - 1) begin : g_last
			assign re = '0;
		end else begin : g_inner
			assign re = ent[i+1];
		end
		lom_cell #(.IDX_W(IDX_W), .IDX(i), .IS_ASK(IS_ASK)) u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.cmd          (cmd),
			.cmd_idx      (cmd_idx),
			.left_valid   (lv),
			.right_entry  (re),
			.best_in      (bchain[i]),
			.best_idx_in  (ichain[i]),
			.entry        (ent[i]),
			.best_out     (bchain[i+1]),
			.best_idx_out (ichain[i+1])
		);
	end

	assign best     = bchain[DEPTH];
	assign best_idx = ichain[DEPTH];
	assign full     = ent[DEPTH-1].valid;

endmodule

[tb/sv/tb_limit_order_matcher_core.sv]
module tb_limit_order_matcher_core;
	import lom_pkg::*;

	localparam int DEPTH = 16;
	localparam int RANDOM_ORDERS = 285;
	localparam int WATCHDOG_LIMIT = 20000;

	logic         clk;
	logic         arst_n;
	logic         order_valid;
	logic         order_stall;
	order_word_t  order;
	logic         report_valid;
	logic         report_stall;
	report_word_t report;

	limit_order_matcher_core #(.BOOK_DEPTH(DEPTH)) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.order_valid(order_valid),
		.order_stall(order_stall),
		.order(order),
		.report_valid(report_valid),
		.report_stall(report_stall),
		.report(report)
	);

	// resting books of the predictor, compacted in arrival order
	typedef struct {
		logic [31:0] price;
		logic [15:0] qty;
		logic [31:0] tag;
		logic [15:0] client;
	} resting_t;

	resting_t     bid_book[$];
	resting_t     ask_book[$];
	report_word_t pending_reports[$];

	int  mismatches = 0;
	int  orders_sent = 0;
	int  reports_seen = 0;
	int  fills_seen = 0;
	int  rejects_seen = 0;
	int  idle_cycles = 0;
	bit  stimulus_done = 0;
	bit  quiet_phase = 0;
	bit  hold_reports = 0;
	bit  timed_out = 0;

	always #4 clk = ~clk;

	function automatic report_word_t make_report(logic [31:0] tag, logic [15:0] client,
			logic side, logic [31:0] price, logic [15:0] qty, logic [1:0] status);
		report_word_t r;
		r.report_tag = tag;
		r.report_client = client;
		r.report_side = side;
		r.report_price = price;
		r.report_quantity = qty;
		r.report_status = status;
		r.report_last = 1'b0;
		return r;
	endfunction

	// match one order against the books and queue the reports it causes
	task automatic match_order(input order_word_t o);
		logic [15:0] remaining;
		int          best;
		int          first;
		resting_t    entry;
		logic        crosses;
		logic [15:0] traded;
		remaining = o.order_quantity;
		first = pending_reports.size();
		if (remaining == 0) begin
			pending_reports = {pending_reports, make_report(o.order_tag, o.client_tag,
				o.side, o.limit_price, 16'd0, ST_REJECT)};
		end else begin
			while (remaining > 0) begin
				best = -1;
				if (o.side == SIDE_BUY) begin
					foreach (ask_book[i])
						if (best < 0 || ask_book[i].price < ask_book[best].price) best = i;
					if (best < 0) break;
					entry = ask_book[best];
					crosses = entry.price <= o.limit_price;
				end else begin
					foreach (bid_book[i])
						if (best < 0 || bid_book[i].price > bid_book[best].price) best = i;
					if (best < 0) break;
					entry = bid_book[best];
					crosses = entry.price >= o.limit_price;
				end
				if (!crosses) break;
				traded = (remaining < entry.qty) ? remaining : entry.qty;
				pending_reports = {pending_reports, make_report(o.order_tag, o.client_tag,
					o.side, entry.price, traded,
					(remaining <= entry.qty) ? ST_FILL : ST_PARTIAL)};
				pending_reports = {pending_reports, make_report(entry.tag, entry.client,
					~o.side, entry.price, traded,
					(entry.qty <= remaining) ? ST_FILL : ST_PARTIAL)};
				remaining -= traded;
				entry.qty -= traded;
				if (o.side == SIDE_BUY) begin
					if (entry.qty == 0) ask_book.delete(best);
					else ask_book[best].qty = entry.qty;
				end else begin
					if (entry.qty == 0) bid_book.delete(best);
					else bid_book[best].qty = entry.qty;
				end
			end
			if (remaining > 0) begin
				entry.price = o.limit_price;
				entry.qty = remaining;
				entry.tag = o.order_tag;
				entry.client = o.client_tag;
				if (o.side == SIDE_BUY && bid_book.size() < DEPTH) begin
					bid_book = {bid_book, entry};
					pending_reports = {pending_reports, make_report(o.order_tag,
						o.client_tag, o.side, o.limit_price, remaining, ST_NEW)};
				end else if (o.side == SIDE_SELL && ask_book.size() < DEPTH) begin
					ask_book = {ask_book, entry};
					pending_reports = {pending_reports, make_report(o.order_tag,
						o.client_tag, o.side, o.limit_price, remaining, ST_NEW)};
				end else begin
					pending_reports = {pending_reports, make_report(o.order_tag,
						o.client_tag, o.side, o.limit_price, remaining, ST_REJECT)};
				end
			end
		end
		if (pending_reports.size() > first)
			pending_reports[pending_reports.size() - 1].report_last = 1'b1;
	endtask

	// compare every accepted report word with the oldest pending one
	always @(posedge clk) begin
		report_word_t want;
		if (arst_n && report_valid && !report_stall) begin
			reports_seen++;
			if (report.report_status == ST_FILL) fills_seen++;
			if (report.report_status == ST_REJECT) rejects_seen++;
			if (pending_reports.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected report word %h", report);
			end else begin
				want = pending_reports.pop_front();
				if (report !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("report mismatch: tag %h/%h client %h/%h side %b/%b price %h/%h qty %h/%h status %0d/%0d last %b/%b",
							want.report_tag, report.report_tag,
							want.report_client, report.report_client,
							want.report_side, report.report_side,
							want.report_price, report.report_price,
							want.report_quantity, report.report_quantity,
							want.report_status, report.report_status,
							want.report_last, report.report_last);
				end
			end
		end
	end

	// predict on every accepted order word
	always @(posedge clk) begin
		if (arst_n && order_valid && !order_stall) begin
			match_order(order);
			orders_sent++;
		end
	end

	// watchdog on cycles with no handshake at all
	always @(posedge clk) begin
		if ((order_valid && !order_stall) || (report_valid && !report_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			timed_out = 1;
			$display("watchdog expired, %0d reports still pending", pending_reports.size());
			$display("limit_order_matcher_core regression: fail");
			$finish;
		end
	end

	// receiver: random stall bursts, plus a long hold on request
	initial begin
		int burst;
		report_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_reports) begin
				report_stall <= 1'b1;
				repeat (300) @(negedge clk);
				hold_reports = 0;
				report_stall <= 1'b0;
			end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
				burst = $urandom_range(1, 3);
				report_stall <= 1'b1;
				repeat (burst) @(negedge clk);
				report_stall <= 1'b0;
			end else begin
				report_stall <= 1'b0;
			end
		end
	end

	// hold one order word until it is taken, sometimes after a random gap outside the quiet phase
	task automatic send_order(input order_word_t o);
		int gap;
		if (!quiet_phase && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 3);
			order_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		order <= o;
		order_valid <= 1'b1;
		@(posedge clk);
		while (order_stall) @(posedge clk);
		@(negedge clk);
	endtask

	function automatic order_word_t pack_order(logic [31:0] tag, logic [15:0] client,
			logic side, logic [31:0] price, logic [15:0] qty);
		order_word_t o;
		o.order_tag = tag;
		o.client_tag = client;
		o.side = side;
		o.limit_price = price;
		o.order_quantity = qty;
		return o;
	endfunction

	// directed rows; only rows whose reports are obvious carry them inline
	typedef struct {
		order_word_t  o;
		bit           typed;
		report_word_t r;
	} directed_row_t;

	directed_row_t directed_rows[$];

	task automatic add_row(order_word_t o, bit typed, logic [1:0] status);
		directed_row_t row;
		row.o = o;
		row.typed = typed;
		row.r = make_report(o.order_tag, o.client_tag, o.side, o.limit_price,
			o.order_quantity, status);
		row.r.report_last = 1'b1;
		directed_rows = {directed_rows, row};
	endtask

	function automatic logic [31:0] near_price(logic [31:0] mid);
		return mid + $urandom_range(0, 8) - 4;
	endfunction

	initial begin
		order_word_t o;
		logic [31:0] mid;
		int          kind;
		int          burst_len;
		clk = 1'b0;
		arst_n = 1'b0;
		order_valid = 1'b0;
		order = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// zero quantity rejects, then resting orders at the price extremes
		add_row(pack_order(32'hFFFF_FFFF, 16'hFFFF, SIDE_BUY, 32'hFFFF_FFFF, 16'd0), 1,
			ST_REJECT);
		add_row(pack_order(32'h0, 16'h0, SIDE_SELL, 32'h0, 16'd0), 1, ST_REJECT);
		add_row(pack_order(32'h1, 16'h1, SIDE_BUY, 32'h0, 16'hFFFF), 1, ST_NEW);
		add_row(pack_order(32'h2, 16'h2, SIDE_SELL, 32'hFFFF_FFFF, 16'hFFFF), 1, ST_NEW);
		// equal prices cross, partial then full
		add_row(pack_order(32'h3, 16'h3, SIDE_SELL, 32'h0, 16'd1), 0, ST_NEW);
		add_row(pack_order(32'h4, 16'h4, SIDE_BUY, 32'hFFFF_FFFF, 16'd2), 0, ST_NEW);
		add_row(pack_order(32'hAAAA_5555, 16'h5A5A, SIDE_SELL, 32'h0, 16'hFFFF), 0, ST_NEW);
		// fill the bid book up to the reject
		for (int i = 0; i < DEPTH + 1; i++)
			add_row(pack_order(32'h100 + i, 16'hA5A5, SIDE_BUY, 32'd100 + (i % 3),
				16'd10), 0, ST_NEW);
		// one sell that sweeps every bid
		add_row(pack_order(32'h5555_AAAA, 16'hFFFF, SIDE_SELL, 32'd1, 16'hFFFF), 0, ST_NEW);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].typed) begin
				o = directed_rows[i].o;
				// the model and the typed row must agree on these obvious cases
				send_order(o);
				if (pending_reports.size() != 0 &&
						pending_reports[pending_reports.size() - 1] !== directed_rows[i].r) begin
					mismatches++;
					if (mismatches <= 10)
						$display("directed row %0d: predicted %h, expected %h", i,
							pending_reports[pending_reports.size() - 1], directed_rows[i].r);
				end
			end else begin
				send_order(directed_rows[i].o);
			end
		end
		order_valid <= 1'b0;

		// sender pauses until every report is in
		while (pending_reports.size() != 0) @(negedge clk);

		// long receiver hold while orders keep coming
		hold_reports = 1;
		mid = $urandom_range(1000, 2000);
		for (int i = 0; i < 40; i++)
			send_order(pack_order($urandom, 16'($urandom_range(0, 65535)),
				1'($urandom_range(0, 1)), near_price(mid), 16'($urandom_range(1, 50))));

		// random orders clustered near a drifting mid, some at random prices or with zero quantity
		for (int i = 0; i < RANDOM_ORDERS - 40; i++) begin
			if (i == RANDOM_ORDERS - 80) quiet_phase = 1;
			if ($urandom_range(0, 30) == 0) mid = $urandom;
			kind = $urandom_range(0, 19);
			if (kind == 0)
				o = pack_order($urandom, 16'($urandom_range(0, 65535)),
					1'($urandom_range(0, 1)), $urandom, 16'($urandom_range(0, 65535)));
			else if (kind == 1)
				o = pack_order($urandom, 16'($urandom_range(0, 65535)),
					1'($urandom_range(0, 1)), near_price(mid), 16'd0);
			else begin
				burst_len = $urandom_range(0, 3);
				o = pack_order($urandom, 16'($urandom_range(0, 65535)),
					1'($urandom_range(0, 1)), near_price(mid),
					(burst_len == 0) ? 16'($urandom_range(1, 65535)) :
					16'($urandom_range(1, 60)));
			end
			send_order(o);
		end
		order_valid <= 1'b0;
		stimulus_done = 1;

		while (pending_reports.size() != 0) @(negedge clk);
		repeat (60) @(negedge clk);

		$display("sent %0d orders, checked %0d reports (%0d fills, %0d rejects)",
			orders_sent, reports_seen, fills_seen, rejects_seen);
		$display("books left with %0d bids and %0d asks, %0d mismatches",
			bid_book.size(), ask_book.size(), mismatches);
		if (mismatches == 0 && pending_reports.size() == 0)
			$display("limit_order_matcher_core regression: pass");
		else
			$display("limit_order_matcher_core regression: fail");
		$finish;
	end

endmodule

[limit_order_matcher_core.f]
+incdir+design
design/lom_pkg.sv
design/lom_cell.sv
design/lom_book.sv
design/limit_order_matcher_core.sv
tb/sv/tb_limit_order_matcher_core.sv
